// ===== hw/rtl/apc_pkg.sv =====
// apc_pkg: shared types for the arithmetic progression checker
// used by apc_cell, apc_check and arithmetic_progression_check
package apc_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned DIFF_W  = VALUE_W + 1;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;

  typedef struct packed {
    logic insert;
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef enum logic {
    ST_FILL,
    ST_CHECK
  } apc_state_t;

endpackage

// ===== hw/rtl/apc_cell.sv =====
// apc_cell: one slot of the sorted insertion chain
// depends on apc_pkg
module apc_cell import apc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  value_t     value,
  input  value_t     left_value,
  input  logic       left_ins,
  input  logic       left_occ,
  input  value_t     right_value,
  input  logic       right_occ,
  output value_t     store,
  output logic       occ,
  output logic       ins
);

  // slot takes part in the insertion when empty or holding a larger value
  always_comb begin
    ins = !occ || (store > value);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctrl.clear) begin
      occ <= 1'b0;
    end else if (ctrl.shift) begin
      occ <= right_occ;
    end else if (ctrl.insert) begin
      occ <= occ | left_occ;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      store <= right_value;
    end else if (ctrl.insert) begin
      if (left_ins) begin
        store <= left_value;
      end else if (ins) begin
        store <= value;
      end
    end
  end

endmodule

// ===== hw/rtl/apc_check.sv =====
// apc_check: compares successive differences at the head of the chain
// depends on apc_pkg
module apc_check import apc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  logic   step_en,
  input  value_t head0,
  input  value_t head1,
  output logic   ok
);

  logic  first;
  diff_t step;
  diff_t diff;

  // exact 33-bit difference
  always_comb begin
    diff = diff_t'({head1[VALUE_W-1], head1}) - diff_t'({head0[VALUE_W-1], head0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first <= 1'b1;
      ok    <= 1'b1;
    end else if (start) begin
      first <= 1'b1;
      ok    <= 1'b1;
    end else if (step_en) begin
      first <= 1'b0;
      if (!first && (diff != step)) begin
        ok <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && first) begin
      step <= diff;
    end
  end

endmodule

// ===== hw/rtl/arithmetic_progression_check.sv =====
// Arithmetic progression checker. Values enter one per cycle into a chain of
// MAX_ITEMS cells that keeps them in ascending signed order; a value arriving
// with the chain full is dropped and flags overflow. After the request that
// carries last, the chain shifts toward its head one cell per cycle while the
// head pair's difference is compared with the first one; no new request is
// taken during that check. The check also empties the chain for the next
// set. The result waits in an output register.
// depends on apc_pkg, apc_cell and apc_check
module arithmetic_progression_check import apc_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   item_valid,
  output logic   item_ready,
  input  value_t value,
  input  logic   last,
  output logic   result_valid,
  input  logic   result_ready,
  output logic   is_progression,
  output logic   overflowed
);

  apc_state_t state;
  apc_state_t state_next;

  value_t                 store [MAX_ITEMS];
  logic   [MAX_ITEMS-1:0] occ;
  logic   [MAX_ITEMS-1:0] ins;
  cell_ctrl_t             ctrl;

  logic ovf;
  logic accept;
  logic full;
  logic done;
  logic load;
  logic ok;

  always_comb begin
    full       = occ[MAX_ITEMS-1];
    item_ready = (state == ST_FILL);
    accept     = item_valid && item_ready;
    done       = (state == ST_CHECK) && !occ[1];
    load       = done && (!result_valid || result_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    ctrl.insert = 1'b0;
    ctrl.shift  = 1'b0;
    ctrl.clear  = 1'b0;
    case (state)
      ST_FILL: begin
        ctrl.insert = accept && !full;
        if (accept && last) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        ctrl.shift = occ[1];
        ctrl.clear = load;
        if (load) begin
          state_next = ST_FILL;
        end
      end
      default: begin
        state_next = ST_FILL;
      end
    endcase
  end

  genvar i;
  generate
    for (i = 0; i < MAX_ITEMS; i++) begin : g_cell
      value_t lval;
      logic   lins;
      logic   locc;
      value_t rval;
      logic   rocc;
      if (i == 0) begin : g_head
        assign lval = store[0];
        assign lins = 1'b0;
        assign locc = 1'b1;
      end else begin : g_body
        assign lval = store[i-1];
        assign lins = ins[i-1];
        assign locc = occ[i-1];
      end
      if (i == MAX_ITEMS - 1) begin : g_tail
        assign rval = store[i];
        assign rocc = 1'b0;
      end else begin : g_inner
        assign rval = store[i+1];
        assign rocc = occ[i+1];
      end
      apc_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .value       (value),
        .left_value  (lval),
        .left_ins    (lins),
        .left_occ    (locc),
        .right_value (rval),
        .right_occ   (rocc),
        .store       (store[i]),
        .occ         (occ[i]),
        .ins         (ins[i])
      );
    end
  endgenerate

  apc_check u_check (
    .clk     (clk),
    .rst     (rst),
    .start   (accept && last),
    .step_en (ctrl.shift),
    .head0   (store[0]),
    .head1   (store[1]),
    .ok      (ok)
  );

  // overflow flag for the current set
  always_ff @(posedge clk) begin
    if (rst) begin
      ovf <= 1'b0;
    end else if (load) begin
      ovf <= 1'b0;
    end else if (accept && full) begin
      ovf <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      is_progression <= ok;
      overflowed     <= ovf;
    end
  end

`ifndef SYNTHESIS
  // occupied cells always form a prefix of the chain
  assert property (@(posedge clk) disable iff (rst)
    ((occ + MAX_ITEMS'(1)) & occ) == '0)
    else $error("occupancy is not a prefix");

  // delivering a result leaves the chain empty
  assert property (@(posedge clk) disable iff (rst)
    load |=> (occ == '0))
    else $error("chain not empty after result");

  // overflow only rises on a request that found the chain full
  assert property (@(posedge clk) disable iff (rst)
    $rose(ovf) |-> $past(accept && full))
    else $error("overflow without full chain");

  // no shifting while filling
  assert property (@(posedge clk) disable iff (rst)
    ctrl.insert |-> !ctrl.shift && !ctrl.clear)
    else $error("insert overlaps check");
`endif

endmodule
